// ===== src/pcr_pkg.sv =====
// Shared types, register codes and the color palette of the pixel cursor port.
package pcr_pkg;

   // Palette size and queue depths.
   localparam int PALETTE_ENTRIES   = 256;
   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 4;

   // Configuration register reset values.
   localparam logic [5:0]  BPP_RESET    = 6'd16;
   localparam logic [15:0] STRIDE_RESET = 16'd1280;
   localparam logic [15:0] XRES_RESET   = 16'd640;
   localparam logic [15:0] YRES_RESET   = 16'd480;

   // Cursor state reset values.
   localparam logic [7:0] BRUSH_RESET    = 8'd1;
   localparam logic [7:0] BACKDROP_RESET = 8'd0;

   // Byte returned by a read of a register without read data.
   localparam logic [7:0] READ_FILL = 8'hFF;

   // Bus access direction.
   typedef enum logic {
      REQ_WRITE = 1'b0,
      REQ_READ  = 1'b1
   } req_kind_type;

   // Kind of a result transaction.
   typedef enum logic {
      KIND_STORE = 1'b0,
      KIND_READ  = 1'b1
   } rsp_kind_type;

   // Register offsets within the 16-byte window.
   typedef enum logic [3:0] {
      OFS_BASE_X_LO  = 4'd0,
      OFS_BASE_X_HI  = 4'd1,
      OFS_BASE_Y_LO  = 4'd2,
      OFS_BASE_Y_HI  = 4'd3,
      OFS_PLOT       = 4'd4,
      OFS_PLOT_RIGHT = 4'd5,
      OFS_PLOT_DOWN  = 4'd6,
      OFS_PLOT_LEFT  = 4'd7,
      OFS_PLOT_UP    = 4'd8,
      OFS_NEXT_ROW   = 4'd9,
      OFS_NEXT_COL   = 4'd10,
      OFS_PAN        = 4'd11,
      OFS_SPARE_A    = 4'd12,
      OFS_SPARE_B    = 4'd13,
      OFS_BRUSH      = 4'd14,
      OFS_BACKDROP   = 4'd15
   } offset_type;

   // Configuration register indexes.
   typedef enum logic [1:0] {
      CSR_BPP    = 2'd0,
      CSR_STRIDE = 2'd1,
      CSR_XRES   = 2'd2,
      CSR_YRES   = 2'd3
   } csr_index_type;

   // Input transaction.
   typedef struct packed {
      logic       req_type;
      logic [3:0] reg_offset;
      logic [7:0] write_data;
   } request_type;

   // Result transaction.
   typedef struct packed {
      logic        result_kind;
      logic [31:0] pixel_byte_address;
      logic [15:0] pixel_value;
      logic [7:0]  read_data;
   } response_type;

   // Classified work handed from the front end to the back end.
   typedef struct packed {
      logic        kind;
      logic [15:0] pos_x;
      logic [15:0] pos_y;
      logic [7:0]  color_index;
      logic [7:0]  read_data;
   } command_type;

   // RGB565 palette; the last entry is black.
   localparam logic [15:0] PALETTE [PALETTE_ENTRIES] = '{
      16'h0000,16'h7bcf,16'h0008,16'h73ca,16'h610c,16'h2b00,16'h5000,16'h3b8e,
      16'h2a0d,16'h0106,16'h39cf,16'h18c3,16'h39c7,16'h33ca,16'h7a00,16'h5acb,
      16'h0000,16'h0841,16'h1082,16'h18c3,16'h2104,16'h2945,16'h3186,16'h39c7,
      16'h4208,16'h4a49,16'h528a,16'h5acb,16'h630c,16'h6b4d,16'h738e,16'h7bcf,
      16'h0842,16'h18c4,16'h2106,16'h3188,16'h420a,16'h4a4c,16'h5acf,16'h0842,
      16'h1084,16'h18c6,16'h2108,16'h294a,16'h318c,16'h39cf,16'h0002,16'h0844,
      16'h0846,16'h1088,16'h108a,16'h18cc,16'h18cf,16'h0002,16'h0004,16'h0006,
      16'h0008,16'h000a,16'h000c,16'h000f,16'h0882,16'h1904,16'h2186,16'h3208,
      16'h428a,16'h4b0c,16'h5b8f,16'h0842,16'h10c4,16'h1946,16'h21c8,16'h2a4a,
      16'h32cc,16'h3b4f,16'h0042,16'h08c4,16'h0946,16'h1188,16'h120a,16'h1a8c,
      16'h1b0f,16'h0042,16'h00c4,16'h0106,16'h0188,16'h020a,16'h024c,16'h02cf,
      16'h0881,16'h1903,16'h2185,16'h3207,16'h4289,16'h4b0b,16'h5bcd,16'h0881,
      16'h1103,16'h1984,16'h2206,16'h2a88,16'h3309,16'h3bcb,16'h0081,16'h0902,
      16'h0984,16'h1205,16'h1286,16'h1b08,16'h1bc9,16'h0081,16'h0102,16'h0183,
      16'h0204,16'h0285,16'h0306,16'h03c7,16'h0881,16'h1903,16'h2984,16'h3206,
      16'h4288,16'h5309,16'h63cb,16'h0881,16'h1102,16'h2183,16'h2a04,16'h3285,
      16'h4306,16'h4bc7,16'h0080,16'h0901,16'h1181,16'h1a02,16'h2282,16'h2b03,
      16'h33c3,16'h0080,16'h0900,16'h0980,16'h1200,16'h1280,16'h1b00,16'h1bc0,
      16'h1081,16'h2103,16'h3184,16'h4206,16'h5288,16'h6309,16'h7bcb,16'h1081,
      16'h2102,16'h3183,16'h4204,16'h5285,16'h6306,16'h7bc7,16'h1080,16'h2101,
      16'h3181,16'h4202,16'h5282,16'h6303,16'h7bc3,16'h1080,16'h2100,16'h3180,
      16'h4200,16'h5280,16'h6300,16'h7bc0,16'h1041,16'h20c3,16'h3144,16'h4186,
      16'h5208,16'h6289,16'h7b0b,16'h1041,16'h2082,16'h3103,16'h4144,16'h5185,
      16'h6206,16'h7a47,16'h1000,16'h2041,16'h3081,16'h40c2,16'h5102,16'h6143,
      16'h7983,16'h1000,16'h2040,16'h3040,16'h4080,16'h5080,16'h60c0,16'h78c0,
      16'h1041,16'h20c3,16'h3105,16'h4187,16'h5209,16'h624b,16'h7acd,16'h1041,
      16'h2083,16'h30c4,16'h4106,16'h5148,16'h6189,16'h79cb,16'h1001,16'h2042,
      16'h3044,16'h4085,16'h5086,16'h60c8,16'h78c9,16'h1001,16'h2002,16'h3003,
      16'h4004,16'h5005,16'h6006,16'h7807,16'h1042,16'h20c4,16'h3106,16'h4188,
      16'h520a,16'h624c,16'h72cf,16'h0842,16'h1884,16'h28c6,16'h3908,16'h494a,
      16'h598c,16'h69cf,16'h0802,16'h1844,16'h2846,16'h3088,16'h408a,16'h50cc,
      16'h60cf,16'h0802,16'h1804,16'h2006,16'h3008,16'h400a,16'h480c,16'h0000
   };

endpackage

// ===== src/pcr_fifo.sv =====
// Small flip-flop queue used between the front end, the back end and the result port.
module pcr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   // Status and handshake qualification.
   assign full     = (count_ff == CNT_W'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   // Pointer and occupancy updates; pointers wrap at the depth.
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Storage needs no reset.
   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== src/pcr_front.sv =====
// Front end: accepts bus transactions, keeps the cursor state and classifies each access.
module pcr_front (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  pcr_pkg::request_type req_payload,
   input  logic [15:0]          x_resolution,
   input  logic [15:0]          y_resolution,
   input  logic                 cmd_full,
   output logic                 cmd_push,
   output pcr_pkg::command_type cmd_data
);

   logic [15:0] base_x_ff, base_x_in;
   logic [15:0] base_y_ff, base_y_in;
   logic [15:0] cursor_x_ff, cursor_x_in;
   logic [15:0] cursor_y_ff, cursor_y_in;
   logic [7:0]  brush_ff, brush_in;
   logic [7:0]  backdrop_ff, backdrop_in;
   logic        take;
   logic        emit;
   logic [15:0] plot_x;
   logic [15:0] plot_y;
   logic [7:0]  rd_byte;
   logic [7:0]  wdata;

   assign take  = push & ~cmd_full;
   assign wdata = req_payload.write_data;

   // Register read data.
   always_comb begin
      unique case (req_payload.reg_offset)
         pcr_pkg::OFS_BASE_X_LO: rd_byte = x_resolution[7:0];
         pcr_pkg::OFS_BASE_X_HI: rd_byte = x_resolution[15:8];
         pcr_pkg::OFS_BASE_Y_LO: rd_byte = y_resolution[7:0];
         pcr_pkg::OFS_BASE_Y_HI: rd_byte = y_resolution[15:8];
         default:                rd_byte = pcr_pkg::READ_FILL;
      endcase
   end

   // Write decode: state moves and the plot position.
   always_comb begin
      base_x_in   = base_x_ff;
      base_y_in   = base_y_ff;
      cursor_x_in = cursor_x_ff;
      cursor_y_in = cursor_y_ff;
      brush_in    = brush_ff;
      backdrop_in = backdrop_ff;
      plot_x      = cursor_x_ff;
      plot_y      = cursor_y_ff;
      emit        = 1'b0;
      unique case (req_payload.reg_offset)
         pcr_pkg::OFS_BASE_X_LO: begin
            base_x_in   = {base_x_ff[15:8], wdata};
            cursor_x_in = {base_x_ff[15:8], wdata};
         end
         pcr_pkg::OFS_BASE_X_HI: begin
            base_x_in   = {wdata, base_x_ff[7:0]};
            cursor_x_in = {wdata, base_x_ff[7:0]};
         end
         pcr_pkg::OFS_BASE_Y_LO: begin
            base_y_in   = {base_y_ff[15:8], wdata};
            cursor_y_in = {base_y_ff[15:8], wdata};
         end
         pcr_pkg::OFS_BASE_Y_HI: begin
            base_y_in   = {wdata, base_y_ff[7:0]};
            cursor_y_in = {wdata, base_y_ff[7:0]};
         end
         pcr_pkg::OFS_PLOT: begin
            emit = 1'b1;
         end
         pcr_pkg::OFS_PLOT_RIGHT: begin
            emit        = 1'b1;
            cursor_x_in = cursor_x_ff + 16'd1;
         end
         pcr_pkg::OFS_PLOT_DOWN: begin
            emit        = 1'b1;
            cursor_y_in = cursor_y_ff + 16'd1;
         end
         pcr_pkg::OFS_PLOT_LEFT: begin
            emit        = 1'b1;
            cursor_x_in = cursor_x_ff - 16'd1;
         end
         pcr_pkg::OFS_PLOT_UP: begin
            emit        = 1'b1;
            cursor_y_in = cursor_y_ff - 16'd1;
         end
         pcr_pkg::OFS_NEXT_ROW: begin
            emit        = 1'b1;
            base_y_in   = base_y_ff + 16'd1;
            cursor_x_in = base_x_ff;
            cursor_y_in = base_y_ff + 16'd1;
            plot_x      = base_x_ff;
            plot_y      = base_y_ff + 16'd1;
         end
         pcr_pkg::OFS_NEXT_COL: begin
            emit        = 1'b1;
            base_x_in   = base_x_ff + 16'd1;
            cursor_x_in = base_x_ff + 16'd1;
            cursor_y_in = base_y_ff;
            plot_x      = base_x_ff + 16'd1;
            plot_y      = base_y_ff;
         end
         pcr_pkg::OFS_PAN: begin
            emit = 1'b0;
         end
         pcr_pkg::OFS_SPARE_A: begin
            emit = 1'b0;
         end
         pcr_pkg::OFS_SPARE_B: begin
            emit = 1'b0;
         end
         pcr_pkg::OFS_BRUSH: begin
            brush_in = wdata;
         end
         pcr_pkg::OFS_BACKDROP: begin
            backdrop_in = wdata;
         end
      endcase
   end

   // Command toward the back end. Reads carry zero coordinates and palette
   // index zero, which is black, so their address and color fields come out zero.
   always_comb begin
      cmd_data = '0;
      cmd_push = 1'b0;
      if (req_payload.req_type == pcr_pkg::REQ_READ) begin
         cmd_data.kind      = pcr_pkg::KIND_READ;
         cmd_data.read_data = rd_byte;
         cmd_push           = take;
      end else begin
         cmd_data.kind        = pcr_pkg::KIND_STORE;
         cmd_data.pos_x       = plot_x;
         cmd_data.pos_y       = plot_y;
         cmd_data.color_index = wdata;
         cmd_push             = take & emit;
      end
   end

   // Cursor state changes only on an accepted write.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_x_ff   <= '0;
         base_y_ff   <= '0;
         cursor_x_ff <= '0;
         cursor_y_ff <= '0;
         brush_ff    <= pcr_pkg::BRUSH_RESET;
         backdrop_ff <= pcr_pkg::BACKDROP_RESET;
      end else if (take && req_payload.req_type == pcr_pkg::REQ_WRITE) begin
         base_x_ff   <= base_x_in;
         base_y_ff   <= base_y_in;
         cursor_x_ff <= cursor_x_in;
         cursor_y_ff <= cursor_y_in;
         brush_ff    <= brush_in;
         backdrop_ff <= backdrop_in;
      end
   end

   // A brush write lands in the brush register.
   assert property (@(posedge clock) disable iff (reset)
      take && req_payload.req_type == pcr_pkg::REQ_WRITE
         && req_payload.reg_offset == pcr_pkg::OFS_BRUSH
      |=> brush_ff == $past(req_payload.write_data))
      else $error("brush register not updated");

   // A background write lands in the background register.
   assert property (@(posedge clock) disable iff (reset)
      take && req_payload.req_type == pcr_pkg::REQ_WRITE
         && req_payload.reg_offset == pcr_pkg::OFS_BACKDROP
      |=> backdrop_ff == $past(req_payload.write_data))
      else $error("background register not updated");

   // Reads leave the cursor alone.
   assert property (@(posedge clock) disable iff (reset)
      take && req_payload.req_type == pcr_pkg::REQ_READ
      |=> $stable(cursor_x_ff) && $stable(cursor_y_ff))
      else $error("read moved the cursor");

   // Every accepted read yields a command.
   assert property (@(posedge clock) disable iff (reset)
      take && req_payload.req_type == pcr_pkg::REQ_READ |-> cmd_push)
      else $error("read lost its response");

endmodule

// ===== src/pcr_back.sv =====
// Back end: address multiply, palette lookup and assembly of the result transaction.
module pcr_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  cmd_empty,
   input  pcr_pkg::command_type  cmd_data,
   output logic                  cmd_pop,
   input  logic [5:0]            pixel_bits,
   input  logic [15:0]           line_stride_bytes,
   input  logic                  res_full,
   output logic                  res_push,
   output pcr_pkg::response_type res_data
);

   // Products and color held between the multiply and the final add.
   typedef struct packed {
      logic        kind;
      logic [21:0] x_product;
      logic [31:0] y_product;
      logic [15:0] color;
      logic [7:0]  read_data;
   } stage_type;

   stage_type stage_ff, stage_in;
   logic      stage_valid_ff, stage_valid_in;
   logic      advance;
   logic      load;

   // Stage moves on when the result queue has room.
   assign advance  = stage_valid_ff & ~res_full;
   assign load     = ~cmd_empty & (~stage_valid_ff | advance);
   assign cmd_pop  = load;
   assign res_push = advance;

   // Multiply and palette lookup.
   always_comb begin
      stage_in.kind      = cmd_data.kind;
      stage_in.x_product = 22'(cmd_data.pos_x) * 22'(pixel_bits);
      stage_in.y_product = 32'(cmd_data.pos_y) * 32'(line_stride_bytes);
      stage_in.color     = pcr_pkg::PALETTE[cmd_data.color_index];
      stage_in.read_data = cmd_data.read_data;
      stage_valid_in     = load | (stage_valid_ff & ~advance);
   end

   // Byte address: x bits divided by eight plus the row offset, modulo 2^32.
   always_comb begin
      res_data.result_kind        = stage_ff.kind;
      res_data.pixel_byte_address = 32'(stage_ff.x_product[21:3]) + stage_ff.y_product;
      res_data.pixel_value        = stage_ff.color;
      res_data.read_data          = stage_ff.read_data;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else begin
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         stage_ff <= stage_in;
      end
   end

   // A blocked stage keeps its contents.
   assert property (@(posedge clock) disable iff (reset)
      stage_valid_ff && res_full |=> stage_valid_ff && $stable(stage_ff))
      else $error("stalled stage lost its transaction");

   // Results never go into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      res_push |-> !res_full)
      else $error("push into full result queue");

   // A load only takes a waiting command.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> !cmd_empty)
      else $error("pop from empty command queue");

endmodule

// ===== src/pixel_cursor_register_port.sv =====
// Top level of the pixel cursor register port: configuration registers and block wiring.
//
// Usage. Bus accesses enter on the request queue port: an access is taken at a
// clock edge with push high and full low. Writes to the base, brush and
// background offsets and to the pan and spare offsets produce nothing; plot
// writes produce one pixel store transaction (byte address and RGB565 color);
// every read produces one read-data transaction. Results leave through the
// response queue port: the oldest one is shown while empty is low and is taken
// at an edge with pop high.
// An accepted access passes the command queue and the back-end stage register
// to the result queue. Throughput is one transaction per cycle while full is
// low, set by the cursor update and the one-stage multiply and palette lookup.
// When the receiver stops popping, the result queue and then the command queue
// fill and full rises; nothing is dropped.
// Reset (synchronous, active high) empties both queues, clears base and cursor
// and loads the configuration registers with 16 bpp, 1280-byte stride and
// 640 x 480. Configuration writes are always ready and must be made only while
// no transactions are in flight.
module pixel_cursor_register_port #(
   parameter int CMD_DEPTH = pcr_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = pcr_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   output logic                  full,
   input  pcr_pkg::request_type  req_payload,
   output logic                  empty,
   input  logic                  pop,
   output pcr_pkg::response_type rsp_payload,
   input  logic                  valid,
   output logic                  ready,
   input  logic [1:0]            csr_index,
   input  logic [15:0]           csr_data
);

   logic [5:0]            bpp_ff;
   logic [15:0]           stride_ff;
   logic [15:0]           xres_ff;
   logic [15:0]           yres_ff;
   logic                  cmd_push;
   logic                  cmd_pop;
   logic                  cmd_full;
   logic                  cmd_empty;
   pcr_pkg::command_type  cmd_in_data;
   logic [$bits(pcr_pkg::command_type)-1:0] cmd_out_bits;
   pcr_pkg::command_type  cmd_out_data;
   logic                  res_push;
   logic                  res_full;
   pcr_pkg::response_type res_data;
   logic [$bits(pcr_pkg::response_type)-1:0] rsp_bits;

   assign ready        = 1'b1;
   assign full         = cmd_full;
   assign cmd_out_data = pcr_pkg::command_type'(cmd_out_bits);
   assign rsp_payload  = pcr_pkg::response_type'(rsp_bits);

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         bpp_ff    <= pcr_pkg::BPP_RESET;
         stride_ff <= pcr_pkg::STRIDE_RESET;
         xres_ff   <= pcr_pkg::XRES_RESET;
         yres_ff   <= pcr_pkg::YRES_RESET;
      end else if (valid && ready) begin
         unique case (csr_index)
            pcr_pkg::CSR_BPP:    bpp_ff    <= csr_data[5:0];
            pcr_pkg::CSR_STRIDE: stride_ff <= csr_data;
            pcr_pkg::CSR_XRES:   xres_ff   <= csr_data;
            pcr_pkg::CSR_YRES:   yres_ff   <= csr_data;
         endcase
      end
   end

   // Front end: cursor state and access classification.
   pcr_front u_front (
      .clock        (clock),
      .reset        (reset),
      .push         (push),
      .req_payload  (req_payload),
      .x_resolution (xres_ff),
      .y_resolution (yres_ff),
      .cmd_full     (cmd_full),
      .cmd_push     (cmd_push),
      .cmd_data     (cmd_in_data)
   );

   // Command queue between front and back.
   pcr_fifo #(
      .WIDTH ($bits(pcr_pkg::command_type)),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd_push),
      .push_data (cmd_in_data),
      .full      (cmd_full),
      .pop       (cmd_pop),
      .pop_data  (cmd_out_bits),
      .empty     (cmd_empty)
   );

   // Back end: address and color.
   pcr_back u_back (
      .clock             (clock),
      .reset             (reset),
      .cmd_empty         (cmd_empty),
      .cmd_data          (cmd_out_data),
      .cmd_pop           (cmd_pop),
      .pixel_bits        (bpp_ff),
      .line_stride_bytes (stride_ff),
      .res_full          (res_full),
      .res_push          (res_push),
      .res_data          (res_data)
   );

   // Result queue toward the receiver.
   pcr_fifo #(
      .WIDTH ($bits(pcr_pkg::response_type)),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (res_push),
      .push_data (res_data),
      .full      (res_full),
      .pop       (pop),
      .pop_data  (rsp_bits),
      .empty     (empty)
   );

endmodule

// ===== tb/sv/tb.sv =====
// Testbench for the pixel cursor register port: a self-checking test of bus accesses and settings.
`timescale 1ns / 1ps

module tb;
   import pcr_pkg::*;

   localparam int unsigned CYCLE_LIMIT = 400000;
   localparam int unsigned HOLD_CYCLES = 120;
   localparam int unsigned SETTLE_CYCLES = 4;

   // RGB565 colors indexed by the data byte of a plot write; the last entry is black.
   localparam logic [15:0] RGB565_COLORS [256] = '{
      16'h0000,16'h7bcf,16'h0008,16'h73ca,16'h610c,16'h2b00,16'h5000,16'h3b8e,
      16'h2a0d,16'h0106,16'h39cf,16'h18c3,16'h39c7,16'h33ca,16'h7a00,16'h5acb,
      16'h0000,16'h0841,16'h1082,16'h18c3,16'h2104,16'h2945,16'h3186,16'h39c7,
      16'h4208,16'h4a49,16'h528a,16'h5acb,16'h630c,16'h6b4d,16'h738e,16'h7bcf,
      16'h0842,16'h18c4,16'h2106,16'h3188,16'h420a,16'h4a4c,16'h5acf,16'h0842,
      16'h1084,16'h18c6,16'h2108,16'h294a,16'h318c,16'h39cf,16'h0002,16'h0844,
      16'h0846,16'h1088,16'h108a,16'h18cc,16'h18cf,16'h0002,16'h0004,16'h0006,
      16'h0008,16'h000a,16'h000c,16'h000f,16'h0882,16'h1904,16'h2186,16'h3208,
      16'h428a,16'h4b0c,16'h5b8f,16'h0842,16'h10c4,16'h1946,16'h21c8,16'h2a4a,
      16'h32cc,16'h3b4f,16'h0042,16'h08c4,16'h0946,16'h1188,16'h120a,16'h1a8c,
      16'h1b0f,16'h0042,16'h00c4,16'h0106,16'h0188,16'h020a,16'h024c,16'h02cf,
      16'h0881,16'h1903,16'h2185,16'h3207,16'h4289,16'h4b0b,16'h5bcd,16'h0881,
      16'h1103,16'h1984,16'h2206,16'h2a88,16'h3309,16'h3bcb,16'h0081,16'h0902,
      16'h0984,16'h1205,16'h1286,16'h1b08,16'h1bc9,16'h0081,16'h0102,16'h0183,
      16'h0204,16'h0285,16'h0306,16'h03c7,16'h0881,16'h1903,16'h2984,16'h3206,
      16'h4288,16'h5309,16'h63cb,16'h0881,16'h1102,16'h2183,16'h2a04,16'h3285,
      16'h4306,16'h4bc7,16'h0080,16'h0901,16'h1181,16'h1a02,16'h2282,16'h2b03,
      16'h33c3,16'h0080,16'h0900,16'h0980,16'h1200,16'h1280,16'h1b00,16'h1bc0,
      16'h1081,16'h2103,16'h3184,16'h4206,16'h5288,16'h6309,16'h7bcb,16'h1081,
      16'h2102,16'h3183,16'h4204,16'h5285,16'h6306,16'h7bc7,16'h1080,16'h2101,
      16'h3181,16'h4202,16'h5282,16'h6303,16'h7bc3,16'h1080,16'h2100,16'h3180,
      16'h4200,16'h5280,16'h6300,16'h7bc0,16'h1041,16'h20c3,16'h3144,16'h4186,
      16'h5208,16'h6289,16'h7b0b,16'h1041,16'h2082,16'h3103,16'h4144,16'h5185,
      16'h6206,16'h7a47,16'h1000,16'h2041,16'h3081,16'h40c2,16'h5102,16'h6143,
      16'h7983,16'h1000,16'h2040,16'h3040,16'h4080,16'h5080,16'h60c0,16'h78c0,
      16'h1041,16'h20c3,16'h3105,16'h4187,16'h5209,16'h624b,16'h7acd,16'h1041,
      16'h2083,16'h30c4,16'h4106,16'h5148,16'h6189,16'h79cb,16'h1001,16'h2042,
      16'h3044,16'h4085,16'h5086,16'h60c8,16'h78c9,16'h1001,16'h2002,16'h3003,
      16'h4004,16'h5005,16'h6006,16'h7807,16'h1042,16'h20c4,16'h3106,16'h4188,
      16'h520a,16'h624c,16'h72cf,16'h0842,16'h1884,16'h28c6,16'h3908,16'h494a,
      16'h598c,16'h69cf,16'h0802,16'h1844,16'h2846,16'h3088,16'h408a,16'h50cc,
      16'h60cf,16'h0802,16'h1804,16'h2006,16'h3008,16'h400a,16'h480c,16'h0000
   };

   logic         clock;
   logic         reset;
   logic         push;
   logic         full;
   request_type  req_payload;
   logic         empty;
   logic         pop;
   response_type rsp_payload;
   logic         valid;
   logic         ready;
   logic [1:0]   csr_index;
   logic [15:0]  csr_data;

   // Own copy of the settings and the cursor state.
   logic [5:0]  pix_bits;
   logic [15:0] row_stride;
   logic [15:0] width_px;
   logic [15:0] height_px;
   logic [15:0] base_x;
   logic [15:0] base_y;
   logic [15:0] cur_x;
   logic [15:0] cur_y;
   logic [7:0]  brush;
   logic [7:0]  backdrop;

   // Results still owed by the block, oldest first.
   response_type pending_bus_results [$];
   response_type oldest_owed;

   int unsigned errors = 0;
   int unsigned cycles = 0;
   bit          idle_on = 1'b1;
   int unsigned hold_requests = 0;
   int unsigned hold_taken = 0;
   int unsigned pop_stall = 0;

   pixel_cursor_register_port u_top (
      .clock       (clock),
      .reset       (reset),
      .push        (push),
      .full        (full),
      .req_payload (req_payload),
      .empty       (empty),
      .pop         (pop),
      .rsp_payload (rsp_payload),
      .valid       (valid),
      .ready       (ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   // 4 ns clock.
   initial clock = 1'b0;
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   // Idle length for either side: mostly none, sometimes short, rarely long.
   function automatic int unsigned gap_len();
      int unsigned pick;
      if (!idle_on) begin
         return 0;
      end
      pick = $urandom_range(0, 99);
      if (pick < 65) begin
         return 0;
      end
      if (pick < 95) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 30);
   endfunction

   // Byte address and color of a pixel store under the current settings.
   function automatic response_type pixel_store(input logic [15:0] x, input logic [15:0] y,
                                                input logic [7:0] color_idx);
      response_type r;
      logic [31:0]  x_part;
      x_part = (32'(x) * 32'(pix_bits)) / 32'd8;
      r.result_kind        = KIND_STORE;
      r.pixel_byte_address = x_part + 32'(y) * 32'(row_stride);
      r.pixel_value        = RGB565_COLORS[color_idx];
      r.read_data          = 8'd0;
      return r;
   endfunction

   // Apply one bus access to the cursor state and queue the result it owes.
   task automatic cursor_access(input req_kind_type kind, input offset_type ofs,
                                input logic [7:0] d);
      response_type r;
      if (kind == REQ_READ) begin
         r = '0;
         r.result_kind = KIND_READ;
         case (ofs)
            OFS_BASE_X_LO: r.read_data = width_px[7:0];
            OFS_BASE_X_HI: r.read_data = width_px[15:8];
            OFS_BASE_Y_LO: r.read_data = height_px[7:0];
            OFS_BASE_Y_HI: r.read_data = height_px[15:8];
            default:       r.read_data = READ_FILL;
         endcase
         pending_bus_results.push_back(r);
         return;
      end
      case (ofs)
         OFS_BASE_X_LO: begin
            base_x[7:0] = d;
            cur_x = base_x;
         end
         OFS_BASE_X_HI: begin
            base_x[15:8] = d;
            cur_x = base_x;
         end
         OFS_BASE_Y_LO: begin
            base_y[7:0] = d;
            cur_y = base_y;
         end
         OFS_BASE_Y_HI: begin
            base_y[15:8] = d;
            cur_y = base_y;
         end
         OFS_PLOT: begin
            pending_bus_results.push_back(pixel_store(cur_x, cur_y, d));
         end
         OFS_PLOT_RIGHT: begin
            pending_bus_results.push_back(pixel_store(cur_x, cur_y, d));
            cur_x = cur_x + 16'd1;
         end
         OFS_PLOT_DOWN: begin
            pending_bus_results.push_back(pixel_store(cur_x, cur_y, d));
            cur_y = cur_y + 16'd1;
         end
         OFS_PLOT_LEFT: begin
            pending_bus_results.push_back(pixel_store(cur_x, cur_y, d));
            cur_x = cur_x - 16'd1;
         end
         OFS_PLOT_UP: begin
            pending_bus_results.push_back(pixel_store(cur_x, cur_y, d));
            cur_y = cur_y - 16'd1;
         end
         OFS_NEXT_ROW: begin
            base_y = base_y + 16'd1;
            cur_x = base_x;
            cur_y = base_y;
            pending_bus_results.push_back(pixel_store(cur_x, cur_y, d));
         end
         OFS_NEXT_COL: begin
            base_x = base_x + 16'd1;
            cur_x = base_x;
            cur_y = base_y;
            pending_bus_results.push_back(pixel_store(cur_x, cur_y, d));
         end
         OFS_BRUSH:    brush = d;
         OFS_BACKDROP: backdrop = d;
         default: begin
            // Pan and the spare offsets have no effect.
         end
      endcase
   endtask

   // Offer one access, after an optional gap, and wait until it is taken.
   task automatic send_access(input req_kind_type kind, input offset_type ofs,
                              input logic [7:0] d);
      int unsigned gap;
      gap = gap_len();
      if (gap > 0) begin
         push <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_payload <= '{req_type: kind, reg_offset: ofs, write_data: d};
      push <= 1'b1;
      do @(posedge clock); while (full);
      cursor_access(kind, ofs, d);
   endtask

   // Random access, weighted toward plots that move the cursor.
   task automatic send_random_access();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 12) begin
         send_access(REQ_READ, offset_type'($urandom_range(0, 15)), 8'($urandom_range(0, 255)));
      end else if (pick < 27) begin
         send_access(REQ_WRITE, offset_type'($urandom_range(0, 3)), 8'($urandom_range(0, 255)));
      end else if (pick < 87) begin
         send_access(REQ_WRITE, offset_type'($urandom_range(4, 10)), 8'($urandom_range(0, 255)));
      end else begin
         send_access(REQ_WRITE, offset_type'($urandom_range(11, 15)), 8'($urandom_range(0, 255)));
      end
   endtask

   // Stop offering and wait until every owed result has come, plus the pipeline depth.
   task automatic drain();
      push <= 1'b0;
      while (pending_bus_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One configuration write transaction.
   task automatic write_csr(input csr_index_type idx, input logic [15:0] value);
      valid     <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!ready);
      valid <= 1'b0;
      case (idx)
         CSR_BPP:    pix_bits   = value[5:0];
         CSR_STRIDE: row_stride = value;
         CSR_XRES:   width_px   = value;
         CSR_YRES:   height_px  = value;
         default: begin
         end
      endcase
      @(posedge clock);
   endtask

   // Load all four settings once the block has gone idle.
   task automatic set_config(input logic [5:0] bpp, input logic [15:0] stride,
                             input logic [15:0] xres, input logic [15:0] yres);
      drain();
      write_csr(CSR_BPP, 16'(bpp));
      write_csr(CSR_STRIDE, stride);
      write_csr(CSR_XRES, xres);
      write_csr(CSR_YRES, yres);
   endtask

   // Reset settings, field extremes, every offset and the wrap cases.
   task automatic test_directed_accesses();
      send_access(REQ_READ, OFS_BASE_X_LO, 8'h00);
      send_access(REQ_READ, OFS_BASE_X_HI, 8'hFF);
      send_access(REQ_READ, OFS_BASE_Y_LO, 8'h00);
      send_access(REQ_READ, OFS_BASE_Y_HI, 8'h00);
      send_access(REQ_READ, OFS_NEXT_ROW, 8'h00);
      send_access(REQ_WRITE, OFS_BASE_X_LO, 8'hFF);
      send_access(REQ_WRITE, OFS_BASE_X_HI, 8'hFF);
      send_access(REQ_WRITE, OFS_BASE_Y_LO, 8'hFF);
      send_access(REQ_WRITE, OFS_BASE_Y_HI, 8'h7F);
      send_access(REQ_WRITE, OFS_PLOT, 8'h00);
      // The black last palette entry, then the cursor wraps from the right edge to zero.
      send_access(REQ_WRITE, OFS_PLOT_RIGHT, 8'hFF);
      send_access(REQ_WRITE, OFS_PLOT_DOWN, 8'h01);
      // Moving left from zero wraps to the far edge.
      send_access(REQ_WRITE, OFS_PLOT_LEFT, 8'h80);
      send_access(REQ_WRITE, OFS_PLOT_UP, 8'hFE);
      send_access(REQ_WRITE, OFS_NEXT_ROW, 8'h11);
      // The base X steps from its maximum back to zero.
      send_access(REQ_WRITE, OFS_NEXT_COL, 8'h7F);
      send_access(REQ_WRITE, OFS_PAN, 8'hAA);
      send_access(REQ_WRITE, OFS_SPARE_A, 8'h55);
      send_access(REQ_WRITE, OFS_SPARE_B, 8'hFF);
      send_access(REQ_WRITE, OFS_BRUSH, 8'h00);
      send_access(REQ_WRITE, OFS_BACKDROP, 8'hFF);
      send_access(REQ_WRITE, OFS_PLOT, 8'h01);
      send_access(REQ_READ, OFS_BACKDROP, 8'hFF);
      send_access(REQ_READ, OFS_PAN, 8'h00);
   endtask

   // Settings at their extremes, including a zero pixel size and zero stride.
   task automatic test_config_extremes();
      logic [5:0]  bpp_set    [5] = '{6'd0, 6'd63, 6'd1, 6'd32, 6'd16};
      logic [15:0] stride_set [5] = '{16'd0, 16'hFFFF, 16'd1, 16'hFFFF, 16'd1280};
      logic [15:0] xres_set   [5] = '{16'd0, 16'hFFFF, 16'd1, 16'h00FF, 16'd640};
      logic [15:0] yres_set   [5] = '{16'd0, 16'hFFFF, 16'd1, 16'hFF00, 16'd480};
      for (int s = 0; s < 5; s++) begin
         set_config(bpp_set[s], stride_set[s], xres_set[s], yres_set[s]);
         for (int k = 0; k < 4; k++) begin
            send_access(REQ_READ, offset_type'(k), 8'h00);
         end
         // Push the cursor to the far corner so the address wraps.
         send_access(REQ_WRITE, OFS_BASE_X_HI, 8'hFF);
         send_access(REQ_WRITE, OFS_BASE_Y_HI, 8'hFF);
         send_access(REQ_WRITE, OFS_PLOT, 8'($urandom_range(0, 255)));
         repeat (40) send_random_access();
      end
   endtask

   // Long random traffic under changing settings, one phase without idling.
   task automatic test_random_traffic();
      for (int phase = 0; phase < 4; phase++) begin
         set_config(6'($urandom_range(0, 63)), 16'($urandom_range(0, 65535)),
                    16'($urandom_range(0, 65535)), 16'($urandom_range(0, 65535)));
         idle_on = (phase != 2);
         repeat (225) send_random_access();
      end
      idle_on = 1'b1;
   endtask

   // The receiver holds off while plots keep coming, so the queues fill and full rises.
   task automatic test_input_stall();
      drain();
      idle_on = 1'b0;
      hold_requests++;
      repeat (40) begin
         send_access(REQ_WRITE, offset_type'($urandom_range(4, 10)), 8'($urandom_range(0, 255)));
      end
      drain();
      idle_on = 1'b1;
   endtask

   // Result side: random stalls, plus a long hold-off on request.
   always @(posedge clock) begin
      if (reset) begin
         pop <= 1'b0;
      end else if (hold_requests != hold_taken) begin
         hold_taken = hold_requests;
         pop_stall  = HOLD_CYCLES;
         pop <= 1'b0;
      end else if (pop_stall > 0) begin
         pop_stall--;
         pop <= 1'b0;
      end else begin
         pop_stall = gap_len();
         pop <= (pop_stall == 0);
      end
   end

   task automatic check_field(input string name, input logic [31:0] want_v,
                              input logic [31:0] got_v);
      if (want_v !== got_v) begin
         $display("%0t: %s mismatch, expected %h, actual %h", $time, name, want_v, got_v);
         errors++;
      end
   endtask

   // Compare each accepted result transaction with the oldest one owed.
   always @(posedge clock) begin
      if (!reset && !empty && pop) begin
         if (pending_bus_results.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_payload);
            errors++;
         end else begin
            oldest_owed = pending_bus_results.pop_front();
            check_field("result_kind", 32'(oldest_owed.result_kind),
                        32'(rsp_payload.result_kind));
            check_field("pixel_byte_address", oldest_owed.pixel_byte_address,
                        rsp_payload.pixel_byte_address);
            check_field("pixel_value", 32'(oldest_owed.pixel_value),
                        32'(rsp_payload.pixel_value));
            check_field("read_data", 32'(oldest_owed.read_data), 32'(rsp_payload.read_data));
         end
      end
   end

   // Run limit.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("%0t: timeout, %0d results still owed", $time, pending_bus_results.size());
         $display("tb: FAIL");
         $finish;
      end
   end

   // Reset, then the tests in turn.
   initial begin
      reset       <= 1'b1;
      push        <= 1'b0;
      req_payload <= '0;
      valid       <= 1'b0;
      csr_index   <= '0;
      csr_data    <= '0;
      pix_bits    = BPP_RESET;
      row_stride  = STRIDE_RESET;
      width_px    = XRES_RESET;
      height_px   = YRES_RESET;
      base_x      = '0;
      base_y      = '0;
      cur_x       = '0;
      cur_y       = '0;
      brush       = BRUSH_RESET;
      backdrop    = BACKDROP_RESET;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_directed_accesses();
      test_config_extremes();
      test_random_traffic();
      test_input_stall();
      drain();

      if (errors == 0 && pending_bus_results.size() == 0) begin
         $display("tb: PASS");
      end else begin
         $display("tb: FAIL");
      end
      $finish;
   end

endmodule
